// ===== hdl/vorm_pkg.sv =====
`timescale 1ns / 1ps

package vorm_pkg;

	// answer field width and default capacity
	localparam int ANS_W        = 16;
	localparam int DEF_MAX_ROWS = 1024;

	// no-entry marker for lookups
	localparam logic [ANS_W-1:0] NO_ENTRY = '1;

	// operation codes
	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_L2P    = 3'd2,
		OP_P2L    = 3'd3,
		OP_RANK   = 3'd4
	} op_t;

	// write enables for the two offset tables
	typedef struct packed {
		logic l2p;
		logic p2l;
	} tbl_we_t;

endpackage

// ===== hdl/vorm_tables.sv =====
`timescale 1ns / 1ps

module vorm_tables #(
	parameter int MAX_ROWS = vorm_pkg::DEF_MAX_ROWS,
	parameter int IDX_W    = $clog2(MAX_ROWS)
) (
	input  logic                 clk,
	input  vorm_pkg::tbl_we_t    we,
	input  logic [IDX_W-1:0]     l2p_waddr,
	input  logic [IDX_W:0]       l2p_wdata,
	input  logic [IDX_W-1:0]     p2l_waddr,
	input  logic [IDX_W-1:0]     p2l_wdata,
	input  logic [IDX_W-1:0]     l2p_raddr,
	input  logic [IDX_W-1:0]     p2l_raddr,
	output logic [IDX_W:0]       l2p_rdata,
	output logic [IDX_W-1:0]     p2l_rdata
);
	import vorm_pkg::*;

	// logical row -> {valid, slot}
	logic [IDX_W:0]   l2p_mem [MAX_ROWS];
	// slot -> logical row
	logic [IDX_W-1:0] p2l_mem [MAX_ROWS];

	// logical-to-physical table, registered read
	always_ff @(posedge clk) begin
		if (we.l2p) begin
			l2p_mem[l2p_waddr] <= l2p_wdata;
		end
		l2p_rdata <= l2p_mem[l2p_raddr];
	end

	// physical-to-logical table, registered read
	always_ff @(posedge clk) begin
		if (we.p2l) begin
			p2l_mem[p2l_waddr] <= p2l_wdata;
		end
		p2l_rdata <= p2l_mem[p2l_raddr];
	end

endmodule

// ===== hdl/vorm_step.sv =====
`timescale 1ns / 1ps

module vorm_step #(
	parameter int MAX_ROWS = vorm_pkg::DEF_MAX_ROWS,
	parameter int IDX_W    = $clog2(MAX_ROWS),
	parameter int CNT_W    = $clog2(MAX_ROWS + 1)
) (
	input  logic [CNT_W-1:0]          lo,
	input  logic [CNT_W-1:0]          hi,
	input  logic [CNT_W-1:0]          mid,
	input  logic [IDX_W-1:0]          row,
	input  logic [vorm_pkg::ANS_W-1:0] bound,
	output logic [CNT_W-1:0]          lo_n,
	output logic [CNT_W-1:0]          hi_n,
	output logic [CNT_W-1:0]          mid_n,
	output logic                      last
);
	import vorm_pkg::*;

	logic         less;
	logic [CNT_W:0] sum;

	// one halving step of the lower-bound search
	always_comb begin
		less  = ANS_W'(row) < bound;
		lo_n  = less ? CNT_W'(mid + CNT_W'(1)) : lo;
		hi_n  = less ? hi : mid;
		last  = !(lo_n < hi_n);
		sum   = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n = CNT_W'(sum >> 1);
	end

endmodule

// ===== hdl/validity_offset_rank_map.sv =====
`timescale 1ns / 1ps

// Two-way offset map between logical rows and physical slots, built one
// validity bit at a time by append (op 1) and emptied by clear (op 0); it then
// answers logical-to-physical (op 2), physical-to-logical (op 3) and
// count-valid-below (op 4) queries. An op is taken on a clock edge with start
// high and busy low, and its result appears on answer/found/overflow for
// exactly one cycle with done high; there is no way to hold a result, so it
// must be captured in that cycle. Clear, append, unused codes and every query
// answered from the counters alone (disabled map, out-of-range or edge
// bounds) give done in the cycle after start and keep busy low. Lookups read
// one table entry through the registered read port and give done from the
// lookup state. The rank query runs a binary search over the physical-to-logical
// table with one registered table read and one compare per cycle in the search
// state, and gives done once the range closes. Tables are never cleared: only
// entries already written feed an answer.
module validity_offset_rank_map #(
	parameter int MAX_ROWS = vorm_pkg::DEF_MAX_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  op,
	input  logic                        row_valid,
	input  logic signed [vorm_pkg::ANS_W-1:0] query_value,
	output logic                        done,
	output logic signed [vorm_pkg::ANS_W-1:0] answer,
	output logic                        found,
	output logic                        overflow
);
	import vorm_pkg::*;

	localparam int IDX_W = $clog2(MAX_ROWS);
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ROWS);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_SEARCH = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  valid_q;
	logic              enabled_q;
	logic              done_q;
	logic [ANS_W-1:0]  answer_q;
	logic              found_q;
	logic              overflow_q;
	logic              is_l2p_q;
	logic [ANS_W-1:0]  bound_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  mid_q;

	logic              accept;
	tbl_we_t           we;
	logic [IDX_W:0]    l2p_wdata;
	logic [IDX_W-1:0]  l2p_raddr;
	logic [IDX_W-1:0]  p2l_raddr;
	logic [IDX_W:0]    l2p_rdata;
	logic [IDX_W-1:0]  p2l_rdata;
	logic [CNT_W-1:0]  lo_n;
	logic [CNT_W-1:0]  hi_n;
	logic [CNT_W-1:0]  mid_n;
	logic              last;

	logic              q_neg;
	logic [ANS_W-1:0]  q_mag;
	logic [ANS_W-1:0]  tot16;
	logic [ANS_W-1:0]  val16;
	logic [CNT_W-1:0]  mid0;
	logic              imm;
	logic [ANS_W-1:0]  imm_ans;
	logic              imm_ovf;
	logic              go_lookup;
	logic              go_search;
	logic              do_append;
	logic [ANS_W-1:0]  lookup_ans;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// decode of an accepted op against the counters
	always_comb begin
		q_neg     = query_value[ANS_W-1];
		q_mag     = {1'b0, query_value[ANS_W-2:0]};
		tot16     = ANS_W'(total_q);
		val16     = ANS_W'(valid_q);
		mid0      = CNT_W'(valid_q >> 1);
		imm       = 1'b1;
		imm_ans   = val16;
		imm_ovf   = 1'b0;
		go_lookup = 1'b0;
		go_search = 1'b0;
		do_append = 1'b0;
		case (op)
			OP_CLEAR: begin
				imm_ans = '0;
			end
			OP_APPEND: begin
				if (total_q == FULL) begin
					imm_ovf = 1'b1;
				end else begin
					do_append = 1'b1;
					imm_ans   = val16 + ANS_W'(row_valid);
				end
			end
			OP_L2P, OP_P2L: begin
				if (!enabled_q) begin
					imm_ans = query_value;
				end else if (q_neg || q_mag >= ((op == OP_L2P) ? tot16 : val16)) begin
					imm_ans = NO_ENTRY;
				end else begin
					imm       = 1'b0;
					go_lookup = 1'b1;
				end
			end
			OP_RANK: begin
				if (!enabled_q) begin
					imm_ans = q_neg ? '0 : query_value;
				end else if (q_neg || query_value == '0) begin
					imm_ans = '0;
				end else if (q_mag >= tot16) begin
					imm_ans = val16;
				end else if (valid_q == '0) begin
					imm_ans = '0;
				end else begin
					imm       = 1'b0;
					go_search = 1'b1;
				end
			end
			default: begin
				imm_ans = val16;
			end
		endcase
	end

	// table write and read addressing
	always_comb begin
		we.l2p    = accept && do_append;
		we.p2l    = accept && do_append && row_valid;
		l2p_wdata = row_valid ? {1'b1, valid_q[IDX_W-1:0]} : {1'b0, {IDX_W{1'b0}}};
		l2p_raddr = query_value[IDX_W-1:0];
		if (state_q == ST_SEARCH) begin
			p2l_raddr = mid_n[IDX_W-1:0];
		end else if (op == OP_RANK) begin
			p2l_raddr = mid0[IDX_W-1:0];
		end else begin
			p2l_raddr = query_value[IDX_W-1:0];
		end
	end

	// lookup result from the table entry
	always_comb begin
		if (is_l2p_q) begin
			lookup_ans = l2p_rdata[IDX_W] ? ANS_W'(l2p_rdata[IDX_W-1:0]) : NO_ENTRY;
		end else begin
			lookup_ans = ANS_W'(p2l_rdata);
		end
	end

	vorm_tables #(
		.MAX_ROWS (MAX_ROWS),
		.IDX_W    (IDX_W)
	) u_tables (
		.clk       (clk),
		.we        (we),
		.l2p_waddr (total_q[IDX_W-1:0]),
		.l2p_wdata (l2p_wdata),
		.p2l_waddr (valid_q[IDX_W-1:0]),
		.p2l_wdata (total_q[IDX_W-1:0]),
		.l2p_raddr (l2p_raddr),
		.p2l_raddr (p2l_raddr),
		.l2p_rdata (l2p_rdata),
		.p2l_rdata (p2l_rdata)
	);

	vorm_step #(
		.MAX_ROWS (MAX_ROWS),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_step (
		.lo    (lo_q),
		.hi    (hi_q),
		.mid   (mid_q),
		.row   (p2l_rdata),
		.bound (bound_q),
		.lo_n  (lo_n),
		.hi_n  (hi_n),
		.mid_n (mid_n),
		.last  (last)
	);

	// sequencer and map counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			valid_q   <= '0;
			enabled_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_CLEAR) begin
							total_q   <= '0;
							valid_q   <= '0;
							enabled_q <= 1'b0;
						end
						if (op == OP_APPEND) begin
							enabled_q <= 1'b1;
						end
						if (do_append) begin
							total_q <= total_q + CNT_W'(1);
							valid_q <= valid_q + CNT_W'(row_valid);
						end
						done_q <= imm;
						if (go_lookup) begin
							state_q <= ST_LOOKUP;
						end else if (go_search) begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_LOOKUP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SEARCH: begin
					if (last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result and search registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			answer_q   <= imm_ans;
			found_q    <= (imm_ans != NO_ENTRY);
			overflow_q <= imm_ovf;
			is_l2p_q   <= (op == OP_L2P);
			bound_q    <= query_value;
			lo_q       <= '0;
			hi_q       <= valid_q;
			mid_q      <= mid0;
		end else if (state_q == ST_LOOKUP) begin
			answer_q   <= lookup_ans;
			found_q    <= (lookup_ans != NO_ENTRY);
			overflow_q <= 1'b0;
		end else if (state_q == ST_SEARCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
			if (last) begin
				answer_q   <= ANS_W'(lo_n);
				found_q    <= 1'b1;
				overflow_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign answer   = answer_q;
	assign found    = found_q;
	assign overflow = overflow_q;

endmodule

// ===== hdl/vorm_check.sv =====
`timescale 1ns / 1ps

module vorm_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [2:0]                  op,
	input logic                        done,
	input logic [vorm_pkg::ANS_W-1:0]  answer,
	input logic                        found,
	input logic                        overflow
);
	import vorm_pkg::*;

	// a result transfer always ends the op, so the block is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// found flags exactly the answers that are not the no-entry marker
	a_found_marker: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (found == (answer != NO_ENTRY)))
		else $error("found disagrees with answer");

	// a clear reports an empty map on the next cycle
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_CLEAR) |=> (done && answer == '0 && !overflow))
		else $error("clear result wrong");

	// an append is answered in the next cycle with a non-negative count
	a_append_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_APPEND) |=> (done && found && !answer[ANS_W-1]))
		else $error("append result wrong");

endmodule

bind validity_offset_rank_map vorm_check u_vorm_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.op          (op),
	.done        (done),
	.answer      (answer),
	.found       (found),
	.overflow    (overflow)
);
